// ===== src/assert_macros.svh =====
// Assertion macros for the top-level RTL file of the prefix match block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ipsm_pkg.sv =====
// Shared constants and controller/datapath interface types for the prefix match block
`default_nettype none

package ipsm_pkg;

  localparam int NUM_NETS_DEF = 256;
  localparam int V4_BITS      = 32;
  localparam int V6_BITS      = 128;
  localparam int ADDR_W       = 64;
  localparam int LEN_W        = 8;
  localparam int CFG_W        = 9;
  localparam int SLOT_W       = 8;
  // one table entry: family, length, upper and lower address words
  localparam int ENTRY_W      = 1 + LEN_W + 2 * ADDR_W;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef struct packed {
    logic load_we;   // write the input beat into the table
    logic capture;   // latch the query address, clear hit and read pointer
    logic rd_en;     // read the entry at the pointer and advance it
    logic out_load;  // move the hit flag into the output register
  } ipsm_cmd_t;

  typedef struct packed {
    logic count_zero;  // no entry to check
    logic rd_last;     // pointer is at the last checked entry
    logic out_free;    // output register can take a beat this cycle
  } ipsm_stat_t;

endpackage

`default_nettype wire

// ===== src/ip_prefix_set_membership.sv =====
// A load beat is written to the table in the cycle it is accepted.
// A query beat is worked on by a table scan over min(nets_in_use, NUM_NETS) entries,
// which reads one entry per cycle from a single RAM read port.
// One beat is worked on at a time; a load beat can follow the previous one at once.
// Synchronous active-high reset clears the control state, the output valid and
// nets_in_use; table contents are not cleared and must be loaded before use.
`default_nettype none
`include "assert_macros.svh"

module ip_prefix_set_membership
  import ipsm_pkg::*;
#(
  parameter int NUM_NETS = NUM_NETS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  logic [SLOT_W-1:0] entry_index,
  input  logic              is_v6,
  input  logic [ADDR_W-1:0] addr_high,
  input  logic [ADDR_W-1:0] addr_low,
  input  logic [LEN_W-1:0]  prefix_len,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              in_set
);

  ipsm_cmd_t  cmd;
  ipsm_stat_t stat;

  ipsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd)
  );

  ipsm_dp #(
    .NUM_NETS (NUM_NETS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .entry_index (entry_index),
    .is_v6       (is_v6),
    .addr_high   (addr_high),
    .addr_low    (addr_low),
    .prefix_len  (prefix_len),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .in_set      (in_set),
    .cmd         (cmd),
    .stat        (stat)
  );

  `ASSERT_CLK(a_out_load_free, cmd.out_load |-> stat.out_free, "output register full on load")
  `ASSERT_CLK(a_query_busy, cmd.capture |=> in_stall, "input not stalled during scan")
  `ASSERT_CLK(a_load_idle, cmd.load_we |-> !in_stall, "table write outside an accepted beat")
  `ASSERT_ALWAYS(a_reset_out, rst |=> !out_valid, "output valid set right after reset")

endmodule

`default_nettype wire

// ===== src/ipsm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data
`default_nettype none

module ipsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/ipsm_ctrl.sv =====
// Controller state machine: accepts beats and sequences the table scan of a query
`default_nettype none

module ipsm_ctrl
  import ipsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  ipsm_stat_t stat,
  output ipsm_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_QUERY) begin
            cmd.capture = 1'b1;
            state_next  = S_SCAN;
          end else begin
            cmd.load_we = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (stat.count_zero) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_en = 1'b1;
          if (stat.rd_last) begin
            state_next = S_DRAIN;
          end
        end
      end
      // last read data is compared in this cycle
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/ipsm_dp.sv =====
// Datapath: prefix table, query registers, read pointer, masked compare and output register
`default_nettype none

module ipsm_dp
  import ipsm_pkg::*;
#(
  parameter int NUM_NETS = NUM_NETS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  input  logic [SLOT_W-1:0] entry_index,
  input  logic              is_v6,
  input  logic [ADDR_W-1:0] addr_high,
  input  logic [ADDR_W-1:0] addr_low,
  input  logic [LEN_W-1:0]  prefix_len,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              in_set,
  input  ipsm_cmd_t         cmd,
  output ipsm_stat_t        stat
);

  localparam int AW  = (NUM_NETS > 1) ? $clog2(NUM_NETS) : 1;
  localparam int CWN = $clog2(NUM_NETS + 1);
  localparam int CW  = (CWN > CFG_W) ? CWN : CFG_W;
  localparam int FW  = 2 * ADDR_W;

  logic [CFG_W-1:0]  nets_in_use;
  logic [CW-1:0]     count_eff;
  logic [CW-1:0]     cfg_ext;

  // formatted input beat: upper bits cleared for IPv4, length saturated
  logic [ADDR_W-1:0] fmt_hi;
  logic [ADDR_W-1:0] fmt_lo;
  logic [LEN_W-1:0]  fmt_len;
  logic              slot_ok;
  logic [AW-1:0]     waddr;

  logic [ADDR_W-1:0] q_hi;
  logic [ADDR_W-1:0] q_lo;
  logic              q_v6;

  logic [AW-1:0]     rd_ptr;
  logic              rd_vld;
  logic              hit;
  logic              out_valid_next;

  logic [ENTRY_W-1:0] rdata;
  logic               r_v6;
  logic [LEN_W-1:0]   r_len;
  logic [ADDR_W-1:0]  r_hi;
  logic [ADDR_W-1:0]  r_lo;
  logic [FW-1:0]      mask;
  logic [V4_BITS-1:0] mask4;
  logic               match;

  always_comb begin
    fmt_hi = is_v6 ? addr_high : '0;
    fmt_lo = is_v6 ? addr_low : {{(ADDR_W - V4_BITS){1'b0}}, addr_low[V4_BITS-1:0]};
    if (is_v6) begin
      fmt_len = (prefix_len > LEN_W'(V6_BITS)) ? LEN_W'(V6_BITS) : prefix_len;
    end else begin
      fmt_len = (prefix_len > LEN_W'(V4_BITS)) ? LEN_W'(V4_BITS) : prefix_len;
    end
  end

  assign slot_ok = (32'(entry_index) < 32'(NUM_NETS));
  assign waddr   = AW'({{AW{1'b0}}, entry_index});

  ipsm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_NETS)
  ) u_table (
    .clk   (clk),
    .we    (cmd.load_we && slot_ok),
    .waddr (waddr),
    .wdata ({is_v6, fmt_len, fmt_hi, fmt_lo}),
    .re    (cmd.rd_en),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

  assign {r_v6, r_len, r_hi, r_lo} = rdata;

  // stored lengths are already saturated to the family width
  always_comb begin
    mask4 = ~({V4_BITS{1'b1}} >> r_len);
    if (r_v6) begin
      mask = ~({FW{1'b1}} >> r_len);
    end else begin
      mask = {{(FW - V4_BITS){1'b0}}, mask4};
    end
    match = (r_v6 == q_v6) && ((({q_hi, q_lo} ^ {r_hi, r_lo}) & mask) == '0);
  end

  assign cfg_ext   = CW'(nets_in_use);
  assign count_eff = (cfg_ext > CW'(NUM_NETS)) ? CW'(NUM_NETS) : cfg_ext;

  assign stat.count_zero = (count_eff == '0);
  assign stat.rd_last    = (CW'(rd_ptr) + CW'(1) == count_eff);
  assign stat.out_free   = !out_valid || !out_stall;

  always_comb begin
    out_valid_next = out_valid && out_stall;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nets_in_use <= '0;
      rd_vld      <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        nets_in_use <= cfg_wdata;
      end
      rd_vld    <= cmd.rd_en;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_hi   <= fmt_hi;
      q_lo   <= fmt_lo;
      q_v6   <= is_v6;
      rd_ptr <= '0;
      hit    <= 1'b0;
    end else begin
      if (cmd.rd_en) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      // accumulate over the entries read so far
      if (rd_vld && match) begin
        hit <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      in_set <= hit;
    end
  end

endmodule

`default_nettype wire

// ===== bench/ip_prefix_set_membership_tb.sv =====
// Self-checking testbench for the IPv4/IPv6 prefix-list membership block
`timescale 1ns / 1ps

module ip_prefix_set_membership_tb
  import ipsm_pkg::*;
();

  localparam int TABLE_DEPTH = 256;
  localparam int RAND_PHASE_BEATS = 150;

  typedef enum logic {ROW_COUNT, ROW_BEAT} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CFG_W-1:0] count;
    logic             req;
    logic [7:0]       slot;
    logic             v6;
    logic [63:0]      hi;
    logic [63:0]      lo;
    logic [7:0]       plen;
    bit               typed;
    bit               want;
  } plan_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              req_type = REQ_LOAD;
  logic [SLOT_W-1:0] entry_index = '0;
  logic              is_v6 = 1'b0;
  logic [ADDR_W-1:0] addr_high = '0;
  logic [ADDR_W-1:0] addr_low = '0;
  logic [LEN_W-1:0]  prefix_len = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              in_set;

  // prefix table mirror and the count register as the block should hold them
  logic [63:0]      prefix_hi [TABLE_DEPTH];
  logic [63:0]      prefix_lo [TABLE_DEPTH];
  logic [7:0]       prefix_len_tab [TABLE_DEPTH];
  logic             prefix_v6 [TABLE_DEPTH];
  logic [CFG_W-1:0] checked_count = '0;

  bit in_set_due [$];
  int errors = 0;
  bit calm = 1'b0;

  ip_prefix_set_membership dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .entry_index(entry_index), .is_v6(is_v6),
    .addr_high(addr_high), .addr_low(addr_low), .prefix_len(prefix_len),
    .out_valid(out_valid), .out_stall(out_stall), .in_set(in_set)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  plan_row_t plan [0:22] = '{
    '{ROW_COUNT, 9'd0, REQ_LOAD, 8'd0, 1'b0, 64'h0, 64'h0, 8'd0, 1'b0, 1'b0},
    // nothing checked after reset
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b0, 64'h0, 64'h0000_0000_0A00_0001, 8'd0, 1'b1, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_LOAD, 8'd0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_0A00_0000, 8'd8, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_LOAD, 8'd1, 1'b1, 64'h2001_0DB8_0000_0000, 64'h0, 8'd32, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_LOAD, 8'd2, 1'b0, 64'h0, 64'h0000_0000_C0A8_0101, 8'd200, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_LOAD, 8'd3, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_LOAD, 8'd255, 1'b1, 64'h0, 64'h0, 8'd128, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b0, 64'h0, 64'h0000_0000_0A00_0001, 8'd0, 1'b1, 1'b0},
    '{ROW_COUNT, 9'd4, REQ_LOAD, 8'd0, 1'b0, 64'h0, 64'h0, 8'd0, 1'b0, 1'b0},
    // upper bits of an IPv4 query are don't-care
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'hFF, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h1234_5678_0A7F_0001, 8'hFF, 1'b1, 1'b1},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b0, 64'h0, 64'h0000_0000_0B00_0000, 8'd0, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b1, 64'h2001_0DB8_FFFF_0000,
      64'h0123_4567_89AB_CDEF, 8'd0, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b0, 64'h0, 64'h0000_0000_2001_0DB8, 8'd0, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b1, 64'h0, 64'h0000_0000_0A00_0000, 8'd0, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b0, 64'h0, 64'h0000_0000_C0A8_0101, 8'd0, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b0, 64'h0, 64'h0000_0000_C0A8_0100, 8'd0, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 1'b1, 1'b1},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hFFFF_FFFF_FFFF_FFFE, 8'd0, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b1, 64'h0, 64'h0, 8'd0, 1'b0, 1'b0},
    '{ROW_BEAT, 9'd0, REQ_LOAD, 8'd4, 1'b1, 64'h0123_4567_89AB_CDEF,
      64'hFEDC_BA98_7654_3210, 8'd0, 1'b0, 1'b0},
    '{ROW_COUNT, 9'd5, REQ_LOAD, 8'd0, 1'b0, 64'h0, 64'h0, 8'd0, 1'b0, 1'b0},
    // a zero-length IPv6 prefix takes every IPv6 address
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b1, 64'hFEDC_0000_1111_2222,
      64'h3333_4444_5555_6666, 8'd0, 1'b1, 1'b1},
    '{ROW_BEAT, 9'd0, REQ_QUERY, 8'd0, 1'b0, 64'h0, 64'h0000_0000_FFFF_FFFF, 8'd0, 1'b0, 1'b0}
  };

  function automatic logic [127:0] prefix_mask(input logic v6, input int len);
    if (v6)
      return ~128'h0 << (V6_BITS - len);
    return {96'h0, 32'hFFFF_FFFF << (V4_BITS - len)};
  endfunction

  function automatic int entries_checked();
    return (checked_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(checked_count);
  endfunction

  function automatic bit lookup_in_set(input logic v6, input logic [63:0] hi,
                                       input logic [63:0] lo);
    logic [127:0] key;
    bit hit;
    int k;
    key = v6 ? {hi, lo} : {96'h0, lo[31:0]};
    hit = 1'b0;
    for (k = 0; k < entries_checked(); k++) begin
      if (prefix_v6[k] == v6 &&
          ((key ^ {prefix_hi[k], prefix_lo[k]}) &
           prefix_mask(v6, int'(prefix_len_tab[k]))) == '0)
        hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic queue_result(input bit value);
    in_set_due = {in_set_due, value};
  endtask

  // hold valid low until every pending result is out, then let a load settle
  task automatic drain();
    in_valid <= 1'b0;
    while (in_set_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(input logic [CFG_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    checked_count = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic put_beat(input logic req, input logic [7:0] slot, input logic v6,
                          input logic [63:0] hi, input logic [63:0] lo,
                          input logic [7:0] plen, input bit typed, input bit want);
    int cap;
    if (!calm && $urandom_range(0, 59) == 0) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (in_set_due.size() != 0);
    end else if (!calm && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    entry_index <= slot;
    is_v6 <= v6;
    addr_high <= hi;
    addr_low <= lo;
    prefix_len <= plen;
    do @(posedge clk); while (in_stall);
    if (req == REQ_LOAD) begin
      cap = v6 ? V6_BITS : V4_BITS;
      prefix_v6[slot] = v6;
      prefix_hi[slot] = v6 ? hi : 64'h0;
      prefix_lo[slot] = v6 ? lo : {32'h0, lo[31:0]};
      prefix_len_tab[slot] = (plen > cap) ? cap[7:0] : plen;
    end else begin
      queue_result(typed ? want : lookup_in_set(v6, hi, lo));
    end
  endtask

  task automatic random_load(input logic [7:0] slot);
    logic v6;
    logic [7:0] plen;
    int cap;
    int pick;
    v6 = 1'($urandom_range(0, 1));
    cap = v6 ? V6_BITS : V4_BITS;
    pick = $urandom_range(0, 99);
    if (pick < 15)
      plen = 8'($urandom_range(0, 255));
    else if (pick < 25)
      plen = 8'(cap);
    else if (pick < 30)
      plen = '0;
    else
      plen = 8'($urandom_range(cap / 2, cap));
    put_beat(REQ_LOAD, slot, v6, {$urandom, $urandom}, {$urandom, $urandom}, plen,
             1'b0, 1'b0);
  endtask

  // most queries are built from a checked entry, some with one prefix bit flipped
  task automatic random_query();
    logic v6;
    logic [127:0] addr;
    logic [127:0] mask;
    logic [63:0] hi;
    logic [63:0] lo;
    int k;
    int len;
    int width;
    addr = {$urandom, $urandom, $urandom, $urandom};
    v6 = 1'($urandom_range(0, 1));
    if (entries_checked() > 0 && $urandom_range(0, 99) < 65) begin
      k = $urandom_range(0, entries_checked() - 1);
      v6 = prefix_v6[k];
      len = int'(prefix_len_tab[k]);
      width = v6 ? V6_BITS : V4_BITS;
      mask = prefix_mask(v6, len);
      addr = ({prefix_hi[k], prefix_lo[k]} & mask) | (addr & ~mask);
      if (len > 0 && $urandom_range(0, 3) == 0)
        addr[width - 1 - $urandom_range(0, len - 1)] ^= 1'b1;
    end
    if (v6) begin
      hi = addr[127:64];
      lo = addr[63:0];
    end else begin
      hi = {$urandom, $urandom};
      lo = {$urandom, addr[31:0]};
    end
    put_beat(REQ_QUERY, 8'($urandom_range(0, 255)), v6, hi, lo,
             8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 13);
  end

  always @(posedge clk) begin : check_beat
    bit want;
    if (!rst && out_valid && !out_stall) begin
      if (in_set_due.size() == 0) begin
        report_mismatch($sformatf("in_set=%0b with no query pending", in_set));
      end else begin
        want = in_set_due.pop_front();
        if (in_set !== want)
          report_mismatch($sformatf("in_set=%0b, want %0b", in_set, want));
      end
    end
  end

  initial begin
    #30_000_000;
    $display("ip_prefix_set_membership_tb NOT OK");
    $finish;
  end

  initial begin
    int slot_order [TABLE_DEPTH];
    logic [CFG_W-1:0] phase_count [10];
    int i;
    int j;
    int pick;
    int tmp;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].kind == ROW_COUNT)
        write_count(plan[r].count);
      else
        put_beat(plan[r].req, plan[r].slot, plan[r].v6, plan[r].hi, plan[r].lo,
                 plan[r].plen, plan[r].typed, plan[r].want);
    end

    // write every slot once, in shuffled order, so any count is legal afterward
    for (i = 0; i < TABLE_DEPTH; i++) slot_order[i] = i;
    for (i = TABLE_DEPTH - 1; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = slot_order[i];
      slot_order[i] = slot_order[pick];
      slot_order[pick] = tmp;
    end
    for (i = 0; i < TABLE_DEPTH; i++) begin
      random_load(8'(slot_order[i]));
      if ($urandom_range(0, 99) < 30) random_query();
    end

    phase_count = '{9'd256, 9'd511, 9'd1, 9'd0, 9'd0, 9'd255, 9'd257, 9'd0, 9'd128, 9'd0};
    phase_count[4] = 9'($urandom_range(0, 511));
    phase_count[7] = 9'($urandom_range(0, 511));
    phase_count[9] = 9'($urandom_range(0, 511));
    for (i = 0; i < 10; i++) begin
      write_count(phase_count[i]);
      calm = (i == 0);
      for (j = 0; j < RAND_PHASE_BEATS; j++) begin
        if ($urandom_range(0, 99) < 35)
          random_load(8'($urandom_range(0, 255)));
        else
          random_query();
      end
    end
    calm = 1'b0;

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("ip_prefix_set_membership_tb OK");
    else
      $display("ip_prefix_set_membership_tb NOT OK");
    $finish;
  end

endmodule

// ===== ip_prefix_set_membership.f =====
+incdir+src
src/ipsm_pkg.sv
src/ipsm_ram.sv
src/ipsm_ctrl.sv
src/ipsm_dp.sv
src/ip_prefix_set_membership.sv
bench/ip_prefix_set_membership_tb.sv
